FILE: rtl/sha512_pkg.sv
package sha512_pkg;

  localparam int WordW      = 64;
  localparam int NumRounds  = 80;
  localparam int BlockWords = 16;
  localparam int HashWords  = 8;

  typedef logic [WordW-1:0] word_t;

  // Requests from the block sequencer to the compression core.
  typedef struct packed {
    logic load;     // shift one message word into the schedule
    logic start;    // begin 80 rounds on the 16 words held
    logic restart;  // reload the chaining value with the initial hash
  } core_ctrl_t;

  function automatic word_t init_hash(input logic [2:0] idx);
    word_t v;
    case (idx)
      3'd0:    v = 64'h6a09e667f3bcc908;
      3'd1:    v = 64'hbb67ae8584caa73b;
      3'd2:    v = 64'h3c6ef372fe94f82b;
      3'd3:    v = 64'ha54ff53a5f1d36f1;
      3'd4:    v = 64'h510e527fade682d1;
      3'd5:    v = 64'h9b05688c2b3e6c1f;
      3'd6:    v = 64'h1f83d9abfb41bd6b;
      default: v = 64'h5be0cd19137e2179;
    endcase
    return v;
  endfunction

  function automatic word_t round_const(input logic [6:0] idx);
    word_t k;
    case (idx)
      7'd0:  k = 64'h428a2f98d728ae22;
      7'd1:  k = 64'h7137449123ef65cd;
      7'd2:  k = 64'hb5c0fbcfec4d3b2f;
      7'd3:  k = 64'he9b5dba58189dbbc;
      7'd4:  k = 64'h3956c25bf348b538;
      7'd5:  k = 64'h59f111f1b605d019;
      7'd6:  k = 64'h923f82a4af194f9b;
      7'd7:  k = 64'hab1c5ed5da6d8118;
      7'd8:  k = 64'hd807aa98a3030242;
      7'd9:  k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c;
      7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f;
      7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235;
      7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2;
      7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5;
      7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275;
      7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4;
      7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab;
      7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f;
      7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2;
      7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f;
      7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc;
      7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed;
      7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de;
      7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6;
      7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364;
      7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791;
      7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218;
      7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a;
      7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8;
      7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99;
      7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63;
      7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373;
      7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc;
      7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72;
      7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28;
      7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915;
      7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c;
      7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e;
      7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba;
      7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae;
      7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84;
      7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc;
      7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6;
      7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec;
      7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/sha512_core.sv
module sha512_core
  import sha512_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  core_ctrl_t           ctrl,
  input  word_t                load_word,
  output logic                 busy,
  output word_t [HashWords-1:0] chain
);

  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_FINAL} cstate_t;

  localparam logic [6:0] LastRound = 7'(NumRounds - 1);

  cstate_t              state_r;
  logic [6:0]           round_r;
  word_t [HashWords-1:0] chain_r;
  word_t                w_r [BlockWords];
  word_t                v_r [HashWords];

  word_t s0, s1, w_new, big_s0, big_s1, ch, maj, t1, t2;

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  // Schedule: w_r[k] holds W[t+k] during round t.
  always_comb begin
    s0     = rotr(w_r[1], 1) ^ rotr(w_r[1], 8) ^ (w_r[1] >> 7);
    s1     = rotr(w_r[14], 19) ^ rotr(w_r[14], 61) ^ (w_r[14] >> 6);
    w_new  = s1 + w_r[9] + s0 + w_r[0];
    big_s1 = rotr(v_r[4], 14) ^ rotr(v_r[4], 18) ^ rotr(v_r[4], 41);
    big_s0 = rotr(v_r[0], 28) ^ rotr(v_r[0], 34) ^ rotr(v_r[0], 39);
    ch     = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    maj    = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1     = v_r[7] + big_s1 + ch + round_const(round_r) + w_r[0];
    t2     = big_s0 + maj;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      round_r <= '0;
      for (int i = 0; i < HashWords; i++) chain_r[i] <= init_hash(3'(i));
    end else begin
      unique case (state_r)
        C_IDLE: begin
          if (ctrl.restart) begin
            for (int i = 0; i < HashWords; i++) chain_r[i] <= init_hash(3'(i));
          end
          if (ctrl.start) begin
            state_r <= C_ROUND;
            round_r <= '0;
          end
        end
        C_ROUND: begin
          if (round_r == LastRound) begin
            state_r <= C_FINAL;
            round_r <= '0;
          end else begin
            round_r <= round_r + 7'd1;
          end
        end
        C_FINAL: begin
          for (int i = 0; i < HashWords; i++) chain_r[i] <= chain_r[i] + v_r[i];
          state_r <= C_IDLE;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load || state_r == C_ROUND) begin
      for (int i = 0; i < BlockWords - 1; i++) w_r[i] <= w_r[i+1];
      w_r[BlockWords-1] <= (state_r == C_ROUND) ? w_new : load_word;
    end
    if (ctrl.start) begin
      for (int i = 0; i < HashWords; i++) v_r[i] <= chain_r[i];
    end else if (state_r == C_ROUND) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  assign busy  = (state_r != C_IDLE);
  assign chain = chain_r;

endmodule

FILE: rtl/sha512_hash_engine.sv
// SHA-512 engine. Message words stream in on in_*, first byte in the top bits;
// in_tlast ends the message and in_tuser gives its count of valid bytes (only
// honored on the last word, above eight counts as eight). Words are taken one
// per cycle while in_tready is high; the sixteenth of a block starts 80 rounds
// on the shared round unit and holds in_tready low through those rounds, the
// chaining update and the exit from the wait state. After the last word the
// block pushes its padding and length words one per cycle outside those waits,
// compresses one or two more blocks, and then presents the eight digest words
// on out_*, index in out_tuser, out_tlast on the eighth; no new word is taken
// until the final digest word is transferred.
module sha512_hash_engine
  import sha512_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] data_word
  input  logic [3:0]  in_tuser,   // [3:0] valid_bytes
  input  logic        in_tlast,   // last_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast   // digest_last
);

  typedef enum logic [1:0] {S_IN, S_PAD, S_WAIT, S_OUT} state_t;

  localparam logic [3:0] LenSlot   = 4'd14;
  localparam logic [3:0] FillLast  = 4'd15;
  localparam logic [3:0] FullBytes = 4'd8;
  localparam logic [2:0] LastIdx   = 3'(HashWords - 1);
  localparam word_t      PadBit    = {1'b1, {(WordW-1){1'b0}}};
  localparam word_t      AllOnes   = '1;

  state_t         state_r, ret_r;
  logic [3:0]     fill_r;
  logic [127:0]   bits_r;
  logic           extra_r, hi_done_r;
  logic [2:0]     idx_r;

  core_ctrl_t            ctrl;
  logic                  core_busy;
  word_t [HashWords-1:0] chain;

  logic       in_acc, out_acc, push;
  logic [3:0] nbytes;
  logic [5:0] shamt;
  word_t      last_val, push_word;
  logic [6:0] add_bits;

  always_comb begin
    in_acc   = in_tvalid && in_tready;
    out_acc  = out_tvalid && out_tready;
    nbytes   = (in_tuser > FullBytes) ? FullBytes : in_tuser;
    shamt    = {nbytes[2:0], 3'b000};
    // Keep the valid upper bytes and place the 0x80 marker right after them (a full word leaves it to the next word).
    last_val = nbytes[3] ? in_tdata : ((in_tdata & ~(AllOnes >> shamt)) | (PadBit >> shamt));
    add_bits = in_tlast ? {nbytes, 3'b000} : 7'd64;
    push     = (state_r == S_IN && in_acc) || (state_r == S_PAD);
    if (state_r == S_IN) begin
      push_word = in_tlast ? last_val : in_tdata;
    end else if (extra_r) begin
      push_word = PadBit;
    end else if (hi_done_r) begin
      push_word = bits_r[63:0];
    end else if (fill_r == LenSlot) begin
      push_word = bits_r[127:64];
    end else begin
      push_word = '0;
    end
    ctrl.load    = push;
    ctrl.start   = push && (fill_r == FillLast);
    ctrl.restart = out_acc && (idx_r == LastIdx);
  end

  sha512_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .load_word (push_word),
    .busy      (core_busy),
    .chain     (chain)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IN;
      ret_r     <= S_IN;
      fill_r    <= '0;
      bits_r    <= '0;
      extra_r   <= 1'b0;
      hi_done_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      unique case (state_r)
        S_IN: begin
          if (in_acc) begin
            fill_r <= fill_r + 4'd1;
            bits_r <= bits_r + {121'd0, add_bits};
            if (in_tlast) extra_r <= nbytes[3];
            if (fill_r == FillLast) begin
              state_r <= S_WAIT;
              ret_r   <= in_tlast ? S_PAD : S_IN;
            end else if (in_tlast) begin
              state_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          fill_r <= fill_r + 4'd1;
          if (extra_r) begin
            extra_r <= 1'b0;
          end else if (!hi_done_r && fill_r == LenSlot) begin
            hi_done_r <= 1'b1;
          end
          if (fill_r == FillLast) begin
            state_r <= S_WAIT;
            ret_r   <= hi_done_r ? S_OUT : S_PAD;
          end
        end
        S_WAIT: begin
          if (!core_busy) state_r <= ret_r;
        end
        S_OUT: begin
          if (out_tready) begin
            // index wraps back to zero after the eighth word
            idx_r <= idx_r + 3'd1;
            if (idx_r == LastIdx) begin
              // digest done: start over on a fresh message
              state_r   <= S_IN;
              bits_r    <= '0;
              hi_done_r <= 1'b0;
            end
          end
        end
        default: state_r <= S_IN;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IN);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = chain[idx_r];
  assign out_tuser  = idx_r;
  assign out_tlast  = (idx_r == LastIdx);

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and digest handshakes open together");

  a_fill_at_digest: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (fill_r == '0))
    else $error("digest presented with a partial block held");

  a_busy_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    core_busy |-> (state_r == S_WAIT))
    else $error("compression running outside the wait state");

  a_ready_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("not ready for a new message after the digest");
`endif

endmodule

FILE: tb/sha512_hash_engine_tb.sv
module sha512_hash_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sha512_pkg::*;

  localparam int NUM_ITEMS    = 320;
  localparam int NUM_DIR      = 10;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 100;
  localparam int MAX_PRINTS   = 20;

  typedef enum logic [1:0] {
    KNOWN_NONE,
    KNOWN_EMPTY,
    KNOWN_ABC
  } known_digest_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_t;

  typedef struct packed {
    word_t         data;
    logic [3:0]    nbytes;
    logic          lst;
    logic [4:0]    reps;
    known_digest_t known;
  } stim_row_t;

  typedef struct packed {
    word_t      word_val;
    logic [2:0] index;
    logic       is_last;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // [63:0] data_word
  logic [3:0]  in_tuser = '0;   // [3:0] valid_bytes
  logic        in_tlast = 1'b0; // last_word
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // [63:0] digest_word
  logic [2:0]  out_tuser;       // [2:0] word_index
  logic        out_tlast;       // digest_last

  sha512_hash_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  word_t sha_k [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  word_t sha_iv [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  word_t empty_digest [8] = '{
    64'hcf83e1357eefb8bd, 64'hf1542850d66d8007, 64'hd620e4050b5715dc, 64'h83f4a921d36ce9ce,
    64'h47d0d13c5d85f2b0, 64'hff8318d2877eec2f, 64'h63b931bd47417a81, 64'ha538327af927da3e
  };

  word_t abc_digest [8] = '{
    64'hddaf35a193617aba, 64'hcc417349ae204131, 64'h12e6fa4e89a97ea2, 64'h0a9eeee64b55d39a,
    64'h2192992a274fc1a8, 64'h36ba3c23a3feebbd, 64'h454d4423643ce80e, 64'h2a9ac94fa54ca49f
  };

  // Fourteen-word message in the last rows forces the length into a second block.
  stim_row_t dir_rows [NUM_DIR] = '{
    '{64'hffffffffffffffff, 4'd0,  1'b1, 5'd1, KNOWN_EMPTY},
    '{64'h616263ffffffffff, 4'd3,  1'b1, 5'd1, KNOWN_ABC},
    '{64'hffffffffffffffff, 4'd8,  1'b1, 5'd1, KNOWN_NONE},
    '{64'h0123456789abcdef, 4'd15, 1'b1, 5'd1, KNOWN_NONE},
    '{64'hfedcba9876543210, 4'd7,  1'b1, 5'd1, KNOWN_NONE},
    '{64'hffffffffffffffff, 4'd0,  1'b0, 5'd1, KNOWN_NONE},
    '{64'h8000000000000001, 4'd1,  1'b1, 5'd1, KNOWN_NONE},
    '{64'h5555555555555555, 4'd8,  1'b0, 5'd6, KNOWN_NONE},
    '{64'haaaaaaaaaaaaaaaa, 4'd3,  1'b0, 5'd7, KNOWN_NONE},
    '{64'h0000000000000000, 4'd8,  1'b1, 5'd1, KNOWN_NONE}
  };

  // Hash state of the message in flight.
  word_t        hash_state [8];
  word_t        msg_block [16];
  int unsigned  block_fill;
  logic [127:0] msg_bit_len;
  word_t        pred_digest [8];

  digest_beat_t digest_q [$];
  digest_beat_t head_beat;

  int mismatches;
  int words_sent;
  int messages_sent;
  int beats_checked;
  int burst_left;
  int idle_cycles;

  rx_mode_t   rx_mode = RX_ALWAYS;
  logic [6:0] rx_phase = '0;

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = sha_iv[i];
    block_fill  = 0;
    msg_bit_len = '0;
  endfunction

  function automatic void compress_block();
    word_t sched [80];
    word_t a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) sched[i] = msg_block[i];
    for (int i = 16; i < 80; i++) begin
      s0 = rotr(sched[i-15], 1) ^ rotr(sched[i-15], 8) ^ (sched[i-15] >> 7);
      s1 = rotr(sched[i-2], 19) ^ rotr(sched[i-2], 61) ^ (sched[i-2] >> 6);
      sched[i] = s1 + sched[i-7] + s0 + sched[i-16];
    end
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int r = 0; r < 80; r++) begin
      t1 = h + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41)) + ((e & f) ^ (~e & g))
         + sha_k[r] + sched[r];
      t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endfunction

  function automatic void push_block_word(input word_t w);
    msg_block[block_fill] = w;
    block_fill++;
    if (block_fill == 16) begin
      compress_block();
      block_fill = 0;
    end
  endfunction

  // Returns 1 when the word closes a message; the digest is left in pred_digest.
  function automatic bit absorb_word(input word_t data, input logic [3:0] nbytes,
                                     input logic lst);
    int    n;
    word_t keep;
    if (!lst) begin
      msg_bit_len += 128'd64;
      push_block_word(data);
      return 1'b0;
    end
    n = (nbytes > 4'd8) ? 8 : int'(nbytes);
    msg_bit_len += 128'(n * 8);
    if (n == 8) begin
      push_block_word(data);
      push_block_word(64'h8000000000000000);
    end else begin
      keep = (n == 0) ? '0 : ({64{1'b1}} << (64 - 8 * n));
      push_block_word((data & keep) | (64'h80 << (56 - 8 * n)));
    end
    if (block_fill > 14) begin
      while (block_fill != 0) push_block_word('0);
    end
    while (block_fill < 14) push_block_word('0);
    push_block_word(msg_bit_len[127:64]);
    push_block_word(msg_bit_len[63:0]);
    for (int i = 0; i < 8; i++) pred_digest[i] = hash_state[i];
    restart_hash();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    if (mismatches < MAX_PRINTS)
      $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Drive one word and hold it until the transfer, then queue what it produces.
  task automatic send_word(input word_t data, input logic [3:0] nbytes, input logic lst,
                           input known_digest_t known);
    digest_beat_t beat;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= nbytes;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    words_sent++;
    if (absorb_word(data, nbytes, lst)) begin
      messages_sent++;
      for (int i = 0; i < 8; i++) begin
        case (known)
          KNOWN_EMPTY: beat.word_val = empty_digest[i];
          KNOWN_ABC:   beat.word_val = abc_digest[i];
          default:     beat.word_val = pred_digest[i];
        endcase
        beat.index   = 3'(i);
        beat.is_last = (i == 7);
        digest_q.push_back(beat);
      end
    end
  endtask

  // Hold off the sender until every queued digest word has been transferred.
  task automatic drain_digests();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (digest_q.size() != 0);
    burst_left = 0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_q.size() == 0) begin
        report_mismatch("digest word with none pending", out_tdata, '0);
      end else begin
        head_beat = digest_q.pop_front();
        if (out_tdata !== head_beat.word_val)
          report_mismatch("digest_word", out_tdata, head_beat.word_val);
        if (out_tuser !== head_beat.index)
          report_mismatch("word_index", 64'(out_tuser), 64'(head_beat.index));
        if (out_tlast !== head_beat.is_last)
          report_mismatch("digest_last", 64'(out_tlast), 64'(head_beat.is_last));
        beats_checked++;
      end
    end
  end

  always @(posedge clk) begin
    rx_phase <= rx_phase + 7'd1;
    if (rx_phase == '0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_ALWAYS:   out_tready <= 1'b1;
      RX_COIN:     out_tready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: out_tready <= (rx_phase[2:0] != 3'd0) && (rx_phase[2:0] != 3'd3);
      default:     out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    bit         well_formed;
    int         body_len;
    logic [3:0] tail_bytes;
    mismatches    = 0;
    words_sent    = 0;
    messages_sent = 0;
    beats_checked = 0;
    burst_left    = 0;
    idle_cycles   = 0;
    restart_hash();
    for (int i = 0; i < 16; i++) msg_block[i] = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NUM_DIR; r++) begin
      for (int k = 0; k < int'(dir_rows[r].reps); k++)
        send_word(dir_rows[r].data, dir_rows[r].nbytes, dir_rows[r].lst, dir_rows[r].known);
    end
    drain_digests();

    // Mostly clean messages; some carry short inner words or counts above eight.
    while (words_sent < NUM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) drain_digests();
      well_formed = ($urandom_range(0, 99) < 85);
      if ($urandom_range(0, 9) == 0) begin
        body_len = $urandom_range(32, 47);
      end else begin
        body_len = 16 * $urandom_range(0, 1) + $urandom_range(0, 15);
      end
      for (int k = 0; k < body_len; k++)
        send_word({$urandom, $urandom}, well_formed ? 4'd8 : 4'($urandom_range(0, 15)),
                  1'b0, KNOWN_NONE);
      tail_bytes = well_formed ? 4'($urandom_range(0, 8)) : 4'($urandom_range(0, 15));
      send_word({$urandom, $urandom}, tail_bytes, 1'b1, KNOWN_NONE);
    end

    in_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Hashed %0d messages from %0d words (directed and random lengths, short tails).",
             messages_sent, words_sent);
    $display("Checked %0d digest words under random sender gaps and receiver stalls.",
             beats_checked);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/sha512_pkg.sv
rtl/sha512_core.sv
rtl/sha512_hash_engine.sv
tb/sha512_hash_engine_tb.sv
